[rtl/core/mdec_pkg.sv]
// Package for the run-level VLC decoder: shared types, constants and the
// B.14 code table lookup. No dependencies.
package mdec_pkg;

	localparam logic [8:0]  MARKER     = 9'h1ff;
	localparam logic [15:0] EOB_CODE   = 16'hfe00;
	localparam logic [15:0] TRAILER_HI = 16'h3800;
	localparam logic [15:0] LIMIT_RST  = 16'h6f00;

	localparam logic [1:0] ST_MARKER    = 2'd0;
	localparam logic [1:0] ST_LIMIT     = 2'd1;
	localparam logic [1:0] ST_UNMATCHED = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam logic REG_QSCALE = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_PAD, S_TRAILER, S_OUT
	} state_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] len;
		logic [4:0] run;
		logic [5:0] lvl;
	} vlc_t;

	// Table B.14 lookup on a 16-bit window (code bits MSB aligned).
	function automatic vlc_t b14_lookup(input logic [15:0] w);
		vlc_t r;
		r = '0;
		r.hit = 1'b1;
		priority casez (w)
			16'b11??????????????: begin r.len = 5'd2;  r.run = 5'd0;  r.lvl = 6'd1;  end
			16'b011?????????????: begin r.len = 5'd3;  r.run = 5'd1;  r.lvl = 6'd1;  end
			16'b0100????????????: begin r.len = 5'd4;  r.run = 5'd0;  r.lvl = 6'd2;  end
			16'b0101????????????: begin r.len = 5'd4;  r.run = 5'd2;  r.lvl = 6'd1;  end
			16'b00101???????????: begin r.len = 5'd5;  r.run = 5'd0;  r.lvl = 6'd3;  end
			16'b00111???????????: begin r.len = 5'd5;  r.run = 5'd3;  r.lvl = 6'd1;  end
			16'b00110???????????: begin r.len = 5'd5;  r.run = 5'd4;  r.lvl = 6'd1;  end
			16'b000110??????????: begin r.len = 5'd6;  r.run = 5'd1;  r.lvl = 6'd2;  end
			16'b000111??????????: begin r.len = 5'd6;  r.run = 5'd5;  r.lvl = 6'd1;  end
			16'b000101??????????: begin r.len = 5'd6;  r.run = 5'd6;  r.lvl = 6'd1;  end
			16'b000100??????????: begin r.len = 5'd6;  r.run = 5'd7;  r.lvl = 6'd1;  end
			16'b0000110?????????: begin r.len = 5'd7;  r.run = 5'd0;  r.lvl = 6'd4;  end
			16'b0000100?????????: begin r.len = 5'd7;  r.run = 5'd2;  r.lvl = 6'd2;  end
			16'b0000111?????????: begin r.len = 5'd7;  r.run = 5'd8;  r.lvl = 6'd1;  end
			16'b0000101?????????: begin r.len = 5'd7;  r.run = 5'd9;  r.lvl = 6'd1;  end
			16'b00100110????????: begin r.len = 5'd8;  r.run = 5'd0;  r.lvl = 6'd5;  end
			16'b00100001????????: begin r.len = 5'd8;  r.run = 5'd0;  r.lvl = 6'd6;  end
			16'b00100101????????: begin r.len = 5'd8;  r.run = 5'd1;  r.lvl = 6'd3;  end
			16'b00100100????????: begin r.len = 5'd8;  r.run = 5'd3;  r.lvl = 6'd2;  end
			16'b00100111????????: begin r.len = 5'd8;  r.run = 5'd10; r.lvl = 6'd1;  end
			16'b00100011????????: begin r.len = 5'd8;  r.run = 5'd11; r.lvl = 6'd1;  end
			16'b00100010????????: begin r.len = 5'd8;  r.run = 5'd12; r.lvl = 6'd1;  end
			16'b00100000????????: begin r.len = 5'd8;  r.run = 5'd13; r.lvl = 6'd1;  end
			16'b0000001010??????: begin r.len = 5'd10; r.run = 5'd0;  r.lvl = 6'd7;  end
			16'b0000001100??????: begin r.len = 5'd10; r.run = 5'd1;  r.lvl = 6'd4;  end
			16'b0000001011??????: begin r.len = 5'd10; r.run = 5'd2;  r.lvl = 6'd3;  end
			16'b0000001111??????: begin r.len = 5'd10; r.run = 5'd4;  r.lvl = 6'd2;  end
			16'b0000001001??????: begin r.len = 5'd10; r.run = 5'd5;  r.lvl = 6'd2;  end
			16'b0000001110??????: begin r.len = 5'd10; r.run = 5'd14; r.lvl = 6'd1;  end
			16'b0000001101??????: begin r.len = 5'd10; r.run = 5'd15; r.lvl = 6'd1;  end
			16'b0000001000??????: begin r.len = 5'd10; r.run = 5'd16; r.lvl = 6'd1;  end
			16'b000000011101????: begin r.len = 5'd12; r.run = 5'd0;  r.lvl = 6'd8;  end
			16'b000000011000????: begin r.len = 5'd12; r.run = 5'd0;  r.lvl = 6'd9;  end
			16'b000000010011????: begin r.len = 5'd12; r.run = 5'd0;  r.lvl = 6'd10; end
			16'b000000010000????: begin r.len = 5'd12; r.run = 5'd0;  r.lvl = 6'd11; end
			16'b000000011011????: begin r.len = 5'd12; r.run = 5'd1;  r.lvl = 6'd5;  end
			16'b000000010100????: begin r.len = 5'd12; r.run = 5'd2;  r.lvl = 6'd4;  end
			16'b000000011100????: begin r.len = 5'd12; r.run = 5'd3;  r.lvl = 6'd3;  end
			16'b000000010010????: begin r.len = 5'd12; r.run = 5'd4;  r.lvl = 6'd3;  end
			16'b000000011110????: begin r.len = 5'd12; r.run = 5'd6;  r.lvl = 6'd2;  end
			16'b000000010101????: begin r.len = 5'd12; r.run = 5'd7;  r.lvl = 6'd2;  end
			16'b000000010001????: begin r.len = 5'd12; r.run = 5'd8;  r.lvl = 6'd2;  end
			16'b000000011111????: begin r.len = 5'd12; r.run = 5'd17; r.lvl = 6'd1;  end
			16'b000000011010????: begin r.len = 5'd12; r.run = 5'd18; r.lvl = 6'd1;  end
			16'b000000011001????: begin r.len = 5'd12; r.run = 5'd19; r.lvl = 6'd1;  end
			16'b000000010111????: begin r.len = 5'd12; r.run = 5'd20; r.lvl = 6'd1;  end
			16'b000000010110????: begin r.len = 5'd12; r.run = 5'd21; r.lvl = 6'd1;  end
			16'b0000000011010???: begin r.len = 5'd13; r.run = 5'd0;  r.lvl = 6'd12; end
			16'b0000000011001???: begin r.len = 5'd13; r.run = 5'd0;  r.lvl = 6'd13; end
			16'b0000000011000???: begin r.len = 5'd13; r.run = 5'd0;  r.lvl = 6'd14; end
			16'b0000000010111???: begin r.len = 5'd13; r.run = 5'd0;  r.lvl = 6'd15; end
			16'b0000000010110???: begin r.len = 5'd13; r.run = 5'd1;  r.lvl = 6'd6;  end
			16'b0000000010101???: begin r.len = 5'd13; r.run = 5'd1;  r.lvl = 6'd7;  end
			16'b0000000010100???: begin r.len = 5'd13; r.run = 5'd2;  r.lvl = 6'd5;  end
			16'b0000000010011???: begin r.len = 5'd13; r.run = 5'd3;  r.lvl = 6'd4;  end
			16'b0000000010010???: begin r.len = 5'd13; r.run = 5'd5;  r.lvl = 6'd3;  end
			16'b0000000010001???: begin r.len = 5'd13; r.run = 5'd9;  r.lvl = 6'd2;  end
			16'b0000000010000???: begin r.len = 5'd13; r.run = 5'd10; r.lvl = 6'd2;  end
			16'b0000000011111???: begin r.len = 5'd13; r.run = 5'd22; r.lvl = 6'd1;  end
			16'b0000000011110???: begin r.len = 5'd13; r.run = 5'd23; r.lvl = 6'd1;  end
			16'b0000000011101???: begin r.len = 5'd13; r.run = 5'd24; r.lvl = 6'd1;  end
			16'b0000000011100???: begin r.len = 5'd13; r.run = 5'd25; r.lvl = 6'd1;  end
			16'b0000000011011???: begin r.len = 5'd13; r.run = 5'd26; r.lvl = 6'd1;  end
			16'b00000000011111??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd16; end
			16'b00000000011110??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd17; end
			16'b00000000011101??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd18; end
			16'b00000000011100??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd19; end
			16'b00000000011011??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd20; end
			16'b00000000011010??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd21; end
			16'b00000000011001??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd22; end
			16'b00000000011000??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd23; end
			16'b00000000010111??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd24; end
			16'b00000000010110??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd25; end
			16'b00000000010101??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd26; end
			16'b00000000010100??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd27; end
			16'b00000000010011??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd28; end
			16'b00000000010010??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd29; end
			16'b00000000010001??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd30; end
			16'b00000000010000??: begin r.len = 5'd14; r.run = 5'd0;  r.lvl = 6'd31; end
			16'b000000000011000?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd32; end
			16'b000000000010111?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd33; end
			16'b000000000010110?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd34; end
			16'b000000000010101?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd35; end
			16'b000000000010100?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd36; end
			16'b000000000010011?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd37; end
			16'b000000000010010?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd38; end
			16'b000000000010001?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd39; end
			16'b000000000010000?: begin r.len = 5'd15; r.run = 5'd0;  r.lvl = 6'd40; end
			16'b000000000011111?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd8;  end
			16'b000000000011110?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd9;  end
			16'b000000000011101?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd10; end
			16'b000000000011100?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd11; end
			16'b000000000011011?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd12; end
			16'b000000000011010?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd13; end
			16'b000000000011001?: begin r.len = 5'd15; r.run = 5'd1;  r.lvl = 6'd14; end
			16'b0000000000010011: begin r.len = 5'd16; r.run = 5'd1;  r.lvl = 6'd15; end
			16'b0000000000010010: begin r.len = 5'd16; r.run = 5'd1;  r.lvl = 6'd16; end
			16'b0000000000010001: begin r.len = 5'd16; r.run = 5'd1;  r.lvl = 6'd17; end
			16'b0000000000010000: begin r.len = 5'd16; r.run = 5'd1;  r.lvl = 6'd18; end
			16'b0000000000010100: begin r.len = 5'd16; r.run = 5'd6;  r.lvl = 6'd3;  end
			16'b0000000000011010: begin r.len = 5'd16; r.run = 5'd11; r.lvl = 6'd2;  end
			16'b0000000000011001: begin r.len = 5'd16; r.run = 5'd12; r.lvl = 6'd2;  end
			16'b0000000000011000: begin r.len = 5'd16; r.run = 5'd13; r.lvl = 6'd2;  end
			16'b0000000000010111: begin r.len = 5'd16; r.run = 5'd14; r.lvl = 6'd2;  end
			16'b0000000000010110: begin r.len = 5'd16; r.run = 5'd15; r.lvl = 6'd2;  end
			16'b0000000000010101: begin r.len = 5'd16; r.run = 5'd16; r.lvl = 6'd2;  end
			16'b0000000000011111: begin r.len = 5'd16; r.run = 5'd27; r.lvl = 6'd1;  end
			16'b0000000000011110: begin r.len = 5'd16; r.run = 5'd28; r.lvl = 6'd1;  end
			16'b0000000000011101: begin r.len = 5'd16; r.run = 5'd29; r.lvl = 6'd1;  end
			16'b0000000000011100: begin r.len = 5'd16; r.run = 5'd30; r.lvl = 6'd1;  end
			16'b0000000000011011: begin r.len = 5'd16; r.run = 5'd31; r.lvl = 6'd1;  end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/mdec_window.sv]
// Bit window: aligns the 32 bits following the read point of the buffer,
// zero filled past the held bits. Uses mdec_pkg.
module mdec_window (
	input  logic [47:0] buf_bits,
	input  logic [5:0]  held,
	output logic [31:0] win
);
	import mdec_pkg::*;

	logic [79:0] ext;
	logic [79:0] sh;

	// held <= 48; shift so the oldest held bit lands at bit 79
	assign ext = {buf_bits, 32'd0};
	assign sh  = ext << (7'd48 - {1'b0, held});
	assign win = sh[79:48];
endmodule

[rtl/core/mdec_run_level_vlc_decoder.sv]
// Run-level VLC decoder top level: input word buffer, code decode sequencer
// and output register. Uses mdec_pkg and mdec_window.
// Sequence: a word is taken in the idle state and decoded in the decode
// state; each code is then held in the output state until taken, and the
// input stays stalled until the word's codes are out. A frame close goes
// through the pad state, which emits a pad item when the count is odd and
// then the trailer state, or gives the trailer itself when the count is even.
// Reset (arst_n low) idles the block until a word with first_word set.
module mdec_run_level_vlc_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data_word
	input  logic [1:0]  s_tuser,   // first_word, last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // code[15:0], word_count[31:16]
	output logic        m_tlast,   // frame_end
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import mdec_pkg::*;

	state_t      state_q, state_d;
	logic [47:0] buf_q;
	logic [5:0]  held_q;
	logic [15:0] cnt_q;
	logic        inblk_q, done_q, last_q;
	logic [5:0]  qs_q;
	logic [15:0] limit_q;
	logic [1:0]  cls_q;
	logic [15:0] o_code_q, o_wc_q;
	logic        o_end_q;
	logic [1:0]  o_st_q;
	logic [31:0] win;
	vlc_t        hit;

	mdec_window u_win (.buf_bits(buf_q), .held(held_q), .win(win));
	assign hit = b14_lookup(win[31:16]);

	assign s_tready = (state_q == S_IDLE);
	assign m_tdata  = {o_wc_q, o_code_q};
	assign m_tlast  = o_end_q;
	assign m_tuser  = o_st_q;
	assign m_tvalid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qs_q    <= '0;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_QSCALE) qs_q <= cfg_data[5:0];
			else limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Decide what the sequencer does in the decode state
	logic        can_dec, end_word;
	logic        ev_emit, ev_close;
	logic [15:0] ev_code;
	logic [1:0]  ev_st;
	logic [5:0]  ev_drop;
	logic        ev_eob, ev_dc;
	logic [9:0]  lvl;
	logic [16:0] cnt_inc;

	assign cnt_inc = {1'b0, cnt_q} + 17'd1;

	always_comb begin
		can_dec  = last_q ? (held_q != 6'd0) : (held_q >= 6'd22);
		end_word = 1'b0;
		ev_emit  = 1'b0; ev_close = 1'b0; ev_code = '0; ev_st = ST_MARKER;
		ev_drop  = '0; ev_eob = 1'b0; ev_dc = 1'b0;
		lvl = {4'd0, hit.lvl};
		if (win[31 - hit.len]) lvl = 10'd0 - lvl;
		if (!can_dec) begin
			end_word = 1'b1;
			if (last_q) begin ev_close = 1'b1; ev_st = ST_EXHAUSTED; end
		end else if (!inblk_q) begin
			if (win[31:22] == {1'b0, MARKER}) begin
				ev_close = 1'b1; ev_st = ST_MARKER;
			end else begin
				ev_emit = 1'b1; ev_dc = 1'b1; ev_drop = 6'd10;
				ev_code = {qs_q, win[31:22]};
			end
		end else if (win[31:30] == 2'b10) begin
			ev_emit = 1'b1; ev_eob = 1'b1; ev_drop = 6'd2; ev_code = EOB_CODE;
		end else if (win[31:26] == 6'b000001) begin
			ev_emit = 1'b1; ev_drop = 6'd22; ev_code = win[25:10];
		end else if (hit.hit) begin
			ev_emit = 1'b1; ev_drop = 6'(hit.len) + 6'd1;
			ev_code = {1'b0, hit.run, lvl};
		end else begin
			ev_close = 1'b1; ev_st = ST_UNMATCHED;
		end
	end

	logic [5:0] held_new;
	assign held_new = (held_q > ev_drop) ? held_q - ev_drop : 6'd0;

	// ret: state to return to after an emitted item
	typedef enum logic [1:0] { R_DEC, R_PAD, R_TRL, R_IDLE } ret_t;
	ret_t ret_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_tvalid && (s_tuser[0] || !done_q)) state_d = S_DECODE;
			S_DECODE: begin
				if (ev_emit) state_d = S_OUT;
				else if (ev_close) state_d = S_PAD;
				else if (end_word) state_d = S_IDLE;
			end
			S_PAD:     state_d = S_OUT;
			S_TRAILER: state_d = S_OUT;
			S_OUT: if (m_tready) begin
				unique case (ret_q)
					R_DEC:  state_d = S_DECODE;
					R_PAD:  state_d = S_PAD;
					R_TRL:  state_d = S_TRAILER;
					R_IDLE: state_d = S_IDLE;
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	logic [16:0] tot;
	assign tot = {1'b0, cnt_q} + {16'd0, cnt_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0; held_q <= '0; cnt_q <= '0; inblk_q <= 1'b0;
			done_q <= 1'b1; last_q <= 1'b0; cls_q <= '0; ret_q <= R_DEC;
			o_end_q <= 1'b0; o_st_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid && (s_tuser[0] || !done_q)) begin
					if (s_tuser[0]) begin
						buf_q  <= {32'd0, s_tdata};
						held_q <= 6'd16;
						cnt_q  <= '0;
						inblk_q <= 1'b0;
						done_q <= 1'b0;
					end else begin
						buf_q  <= {buf_q[31:0], s_tdata};
						held_q <= (held_q > 6'd32 ? 6'd32 : held_q) + 6'd16;
					end
					last_q <= s_tuser[1];
				end
				S_DECODE: begin
					if (ev_emit) begin
						o_code_q <= ev_code; o_end_q <= 1'b0; o_st_q <= '0; o_wc_q <= '0;
						held_q <= held_new;
						buf_q  <= buf_q & ((48'd1 << held_new) - 48'd1);
						if (cnt_q != 16'hffff) cnt_q <= cnt_inc[15:0];
						if (ev_dc) inblk_q <= 1'b1;
						if (ev_eob) inblk_q <= 1'b0;
						ret_q <= R_DEC;
						if (ev_eob && (cnt_inc[15:0] > limit_q) && cnt_q != 16'hffff) begin
							ret_q <= R_PAD; cls_q <= ST_LIMIT;
						end else if (ev_eob && cnt_q == 16'hffff && cnt_q > limit_q) begin
							ret_q <= R_PAD; cls_q <= ST_LIMIT;
						end
					end else if (ev_close) begin
						cls_q <= ev_st;
					end
				end
				S_PAD: begin
					done_q <= 1'b1; inblk_q <= 1'b0; buf_q <= '0; held_q <= '0;
					if (cnt_q[0]) begin
						o_code_q <= EOB_CODE; o_end_q <= 1'b0; o_st_q <= '0; o_wc_q <= '0;
						ret_q <= R_TRL;
					end else begin
						o_code_q <= TRAILER_HI; o_end_q <= 1'b1; o_st_q <= cls_q;
						o_wc_q <= tot[16:1]; ret_q <= R_IDLE;
					end
				end
				S_TRAILER: begin
					o_code_q <= TRAILER_HI; o_end_q <= 1'b1; o_st_q <= cls_q;
					o_wc_q <= tot[16:1]; ret_q <= R_IDLE;
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end
endmodule

[tb/mdec_checker.sv]
// Checker for the run-level VLC decoder: watches the input, output and config ports,
// predicts every output item and compares it field by field.
// Depends on mdec_pkg for the constants.
`timescale 1ns / 1ps

module mdec_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	import mdec_pkg::*;

	typedef struct packed {
		logic [15:0] code;
		logic        frame_end;
		logic [1:0]  status;
		logic [15:0] word_count;
	} result_t;

	// {length, pattern, run, level}
	localparam logic [31:0] B14 [111] = '{
		32'h02030001, 32'h03030101, 32'h04040002, 32'h04050201, 32'h05050003, 32'h05070301,
		32'h05060401, 32'h06060102, 32'h06070501, 32'h06050601, 32'h06040701, 32'h07060004,
		32'h07040202, 32'h07070801, 32'h07050901, 32'h08260005, 32'h08210006, 32'h08250103,
		32'h08240302, 32'h08270a01, 32'h08230b01, 32'h08220c01, 32'h08200d01,
		32'h0a0a0007, 32'h0a0c0104, 32'h0a0b0203, 32'h0a0f0402, 32'h0a090502,
		32'h0a0e0e01, 32'h0a0d0f01, 32'h0a081001,
		32'h0c1d0008, 32'h0c180009, 32'h0c13000a, 32'h0c10000b, 32'h0c1b0105,
		32'h0c140204, 32'h0c1c0303, 32'h0c120403, 32'h0c1e0602, 32'h0c150702,
		32'h0c110802, 32'h0c1f1101, 32'h0c1a1201, 32'h0c191301, 32'h0c171401,
		32'h0c161501,
		32'h0d1a000c, 32'h0d19000d, 32'h0d18000e, 32'h0d17000f, 32'h0d160106,
		32'h0d150107, 32'h0d140205, 32'h0d130304, 32'h0d120503, 32'h0d110902,
		32'h0d100a02, 32'h0d1f1601, 32'h0d1e1701, 32'h0d1d1801, 32'h0d1c1901,
		32'h0d1b1a01,
		32'h0e1f0010, 32'h0e1e0011, 32'h0e1d0012, 32'h0e1c0013, 32'h0e1b0014,
		32'h0e1a0015, 32'h0e190016, 32'h0e180017, 32'h0e170018, 32'h0e160019,
		32'h0e15001a, 32'h0e14001b, 32'h0e13001c, 32'h0e12001d, 32'h0e11001e,
		32'h0e10001f,
		32'h0f180020, 32'h0f170021, 32'h0f160022, 32'h0f150023, 32'h0f140024,
		32'h0f130025, 32'h0f120026, 32'h0f110027, 32'h0f100028, 32'h0f1f0108,
		32'h0f1e0109, 32'h0f1d010a, 32'h0f1c010b, 32'h0f1b010c, 32'h0f1a010d,
		32'h0f19010e,
		32'h1013010f, 32'h10120110, 32'h10110111, 32'h10100112, 32'h10140603,
		32'h101a0b02, 32'h10190c02, 32'h10180d02, 32'h10170e02, 32'h10160f02,
		32'h10151002, 32'h101f1b01, 32'h101e1c01, 32'h101d1d01, 32'h101c1e01,
		32'h101b1f01
	};

	result_t     expected_q [$];
	logic [5:0]  qscale;
	logic [15:0] limit;
	logic [47:0] bitbuf;
	int          held;
	int          ncodes;
	bit          in_blk;
	bit          done;

	function automatic logic [31:0] peek_bits(input int n);
		logic [63:0] v;
		if (held >= n)
			v = {16'd0, bitbuf} >> (held - n);
		else
			v = {16'd0, bitbuf} << (n - held);
		return 32'(v & ((64'd1 << n) - 64'd1));
	endfunction

	task automatic consume(input int n);
		held = held > n ? held - n : 0;
		bitbuf &= held != 0 ? ((48'd1 << held) - 48'd1) : 48'd0;
	endtask

	task automatic push_code(input logic [15:0] c);
		expected_q.push_back('{c, 1'b0, 2'd0, 16'd0});
		if (ncodes < 65535)
			ncodes++;
	endtask

	task automatic close_frame(input logic [1:0] st);
		int total;
		total = ncodes;
		if (total % 2 == 1) begin
			expected_q.push_back('{EOB_CODE, 1'b0, 2'd0, 16'd0});
			total++;
		end
		expected_q.push_back('{TRAILER_HI, 1'b1, st, 16'(total / 2)});
		done = 1;
		in_blk = 0;
		bitbuf = '0;
		held = 0;
	endtask

	task automatic decode_code(output bit closed);
		logic [31:0] w;
		logic [9:0]  lvl;
		int          len;
		bit          hit;
		closed = 0;
		hit = 0;
		if (!in_blk) begin
			w = peek_bits(10);
			if (w[9:0] == {1'b0, MARKER}) begin
				close_frame(ST_MARKER);
				closed = 1;
			end else begin
				consume(10);
				push_code({qscale, w[9:0]});
				in_blk = 1;
			end
		end else begin
			w = peek_bits(17);
			if (w[16:15] == 2'b10) begin
				consume(2);
				push_code(EOB_CODE);
				in_blk = 0;
				if (ncodes > int'(limit)) begin
					close_frame(ST_LIMIT);
					closed = 1;
				end
			end else if ((w >> 11) == 1) begin
				consume(6);
				push_code(16'(peek_bits(16)));
				consume(16);
			end else begin
				foreach (B14[i]) begin
					len = int'(B14[i][31:24]);
					if (!hit && (w >> (17 - len)) == B14[i][23:16]) begin
						hit = 1;
						lvl = {2'b00, B14[i][7:0]};
						if (((w >> (16 - len)) & 1) != 0)
							lvl = -lvl;
						push_code({B14[i][13:8], lvl});
						consume(len + 1);
					end
				end
				if (!hit) begin
					close_frame(ST_UNMATCHED);
					closed = 1;
				end
			end
		end
	endtask

	task automatic take_word(input logic [15:0] d, input logic first, input logic last);
		bit closed;
		closed = 0;
		if (first) begin
			bitbuf = '0;
			held = 0;
			ncodes = 0;
			in_blk = 0;
			done = 0;
		end
		if (!done) begin
			if (held > 32)
				held = 32;
			bitbuf = {bitbuf[31:0], d};
			held += 16;
			while (!closed && (last ? held != 0 : held >= 22))
				decode_code(closed);
			if (!closed && last)
				close_frame(ST_EXHAUSTED);
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			qscale = '0;
			limit = LIMIT_RST;
			bitbuf = '0;
			held = 0;
			ncodes = 0;
			in_blk = 0;
			done = 1;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_QSCALE)
					qscale = cfg_data[5:0];
				else
					limit = cfg_data;
			end
			if (s_tvalid && s_tready)
				take_word(s_tdata, s_tuser[0], s_tuser[1]);
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", m_tdata, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[15:0] != want.code)
						report("code", 32'(m_tdata[15:0]), 32'(want.code));
					if (m_tlast != want.frame_end)
						report("frame_end", 32'(m_tlast), 32'(want.frame_end));
					if (m_tuser != want.status)
						report("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[31:16] != want.word_count)
						report("word_count", 32'(m_tdata[31:16]), 32'(want.word_count));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

[tb/tb.sv]
// Top of the run-level VLC decoder bench: clock, reset, bitstream frame stimulus,
// config phases and verdict. Depends on mdec_pkg, mdec_checker and the decoder RTL.
`timescale 1ns / 1ps

module tb;
	import mdec_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // data_word
	logic [1:0]  s_tuser;   // first_word, last_word
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // code[15:0], word_count[31:16]
	logic        m_tlast;   // frame_end
	logic [1:0]  m_tuser;   // status
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;

	logic        stream_bits [$];
	int          burst_left;
	int          words_sent;
	int          idle_cycles;
	int          ready_mode;
	int          ready_timer;

	// a handful of table codes across all lengths: {length, pattern}
	localparam logic [15:0] SOME_CODES [14] = '{
		16'h0203, 16'h0303, 16'h0404, 16'h0507, 16'h0606, 16'h0705, 16'h0826,
		16'h0a0a, 16'h0c1d, 16'h0d1b, 16'h0e10, 16'h0f19, 16'h101b, 16'h1013
	};

	mdec_run_level_vlc_decoder dut (.*);

	mdec_checker chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_mode <= 0;
			ready_timer <= 0;
		end else begin
			ready_timer <= ready_timer + 1;
			if (ready_timer % 256 == 255)
				ready_mode <= $urandom_range(0, 2);
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				default: m_tready <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("mdec_run_level_vlc_decoder verification failed");
			$finish;
		end
	end

	task automatic send_word(input logic [15:0] d, input logic first, input logic last);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= {last, first};
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic put_bits(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			stream_bits.push_back(v[i]);
	endtask

	// ending: 0 end marker, 1 runs out of words, 2 a tail of 17 bits, the first 13 zero
	task automatic send_frame(input int nblocks, input int ending, input bit set_last);
		logic [9:0]  dc;
		logic [15:0] c;
		logic [15:0] w;
		int          nwords;
		stream_bits.delete();
		for (int b = 0; b < nblocks; b++) begin
			dc = 10'($urandom_range(0, 1023));
			if (dc == 10'h1ff)
				dc = 10'h000;
			put_bits(32'(dc), 10);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						put_bits(32'h01, 6);
						put_bits($urandom, 16);
					end
					2: put_bits($urandom, 17);
					default: begin
						c = SOME_CODES[$urandom_range(0, 13)];
						put_bits(32'(c[7:0]), int'(c[15:8]));
						put_bits($urandom_range(0, 1), 1);
					end
				endcase
			end
			put_bits(32'h2, 2);
		end
		if (ending == 0)
			put_bits({22'd0, 1'b0, MARKER}, 10);
		else if (ending == 2)
			put_bits($urandom_range(0, 15), 17);
		while (stream_bits.size() % 16 != 0)
			stream_bits.push_back(1'($urandom_range(0, 1)));
		nwords = stream_bits.size() / 16;
		for (int k = 0; k < nwords; k++) begin
			for (int i = 0; i < 16; i++)
				w[15 - i] = stream_bits[k * 16 + i];
			send_word(w, k == 0, set_last && k == nwords - 1);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_QSCALE;
		cfg_data = '0;
		arst_n = 1'b0;
		burst_left = 0;
		words_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored word, all-zero and all-one streams, marker, short frames
		send_word(16'hffff, 1'b0, 1'b0);
		send_word(16'h0000, 1'b1, 1'b1);
		send_word(16'hffff, 1'b1, 1'b0);
		send_word(16'hffff, 1'b0, 1'b1);
		send_word(16'h7fc0, 1'b1, 1'b0);
		send_word(16'h0000, 1'b0, 1'b0);
		send_word(16'h0000, 1'b1, 1'b0);
		send_word(16'h0000, 1'b0, 1'b0);
		send_word(16'h5555, 1'b1, 1'b0);
		send_frame(2, 0, 1'b0);
		send_frame(3, 1, 1'b1);
		send_frame(1, 2, 1'b1);
		send_frame(2, 1, 1'b0);
		send_frame(1, 1, 1'b1);

		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_reg(REG_QSCALE, 16'd63);
					write_reg(REG_LIMIT, 16'd0);
				end
				1: begin
					write_reg(REG_QSCALE, 16'd0);
					write_reg(REG_LIMIT, 16'hffff);
				end
				2: begin
					write_reg(REG_QSCALE, 16'd21);
					write_reg(REG_LIMIT, 16'd5);
				end
				default: begin
					write_reg(REG_QSCALE, 16'($urandom_range(0, 63)));
					write_reg(REG_LIMIT, 16'($urandom_range(0, 40)));
				end
			endcase
			cfg_we <= 1'b0;
			@(posedge clk);
			while (words_sent < 75 * (phase + 1)) begin
				if ($urandom_range(0, 9) == 0)
					send_word(16'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					send_frame($urandom_range(1, 4), $urandom_range(0, 2),
						$urandom_range(0, 4) != 0);
			end
		end

		wait_drained();
		if (errors == 0)
			$display("mdec_run_level_vlc_decoder verification clean");
		else
			$display("mdec_run_level_vlc_decoder verification failed");
		$finish;
	end

endmodule
